>>> hw/rtl/obbsat_pkg.sv
`default_nettype none
package obbsat_pkg;

  localparam int unsigned NumAxes = 4;
  // squared axis length below this (Q2.28) means a degenerate axis
  localparam logic [31:0] AxisEpsQ28 = 32'd26844;
  localparam logic [30:0] DepthMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] a_center_x;
    logic signed [31:0] a_center_y;
    logic signed [15:0] a_axis_cos;
    logic signed [15:0] a_axis_sin;
    logic [30:0]        a_half_width;
    logic [30:0]        a_half_height;
    logic signed [31:0] b_center_x;
    logic signed [31:0] b_center_y;
    logic signed [15:0] b_axis_cos;
    logic signed [15:0] b_axis_sin;
    logic [30:0]        b_half_width;
    logic [30:0]        b_half_height;
  } obbsat_in_t;

  typedef struct packed {
    logic               overlapping;
    logic signed [15:0] push_normal_x;
    logic signed [15:0] push_normal_y;
    logic [30:0]        push_depth;
  } obbsat_out_t;

  // clamp an 18-bit signed value into Q1.14 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/obb_obb_separating_axis.sv
// Separating-axis overlap test for two oriented rectangles. One transaction
// carries both rectangles; one result comes back per transaction. The block
// is a five-stage pipeline (axis dot products, 32x31 radius and 33x17 distance
// multiplies, rounding, overlap, minimum selection into the output register)
// and takes a new pair every cycle while the output is not stalled. An accepted
// transaction passes the stages in order and shows on out_valid once it reaches
// the output register. Each stage holds its data while the stage after it is
// full and stalled, so the block keeps accepting until every stage is occupied.
`default_nettype none
module obb_obb_separating_axis
  import obbsat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire obbsat_in_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output obbsat_out_t      out_data
);

  // stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready  = en1;
  assign out_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // ---------------- stage 1: axes, dot products, centre offset
  logic signed [16:0] px_nxt [NumAxes];
  logic signed [16:0] py_nxt [NumAxes];
  logic [31:0]        dxa_nxt [NumAxes];
  logic [31:0]        dya_nxt [NumAxes];
  logic [31:0]        dxb_nxt [NumAxes];
  logic [31:0]        dyb_nxt [NumAxes];
  logic               use_nxt [NumAxes];
  logic signed [32:0] tx_nxt, ty_nxt;

  logic signed [16:0] px1_r [NumAxes];
  logic signed [16:0] py1_r [NumAxes];
  logic [31:0]        dxa_r [NumAxes];
  logic [31:0]        dya_r [NumAxes];
  logic [31:0]        dxb_r [NumAxes];
  logic [31:0]        dyb_r [NumAxes];
  logic               use1_r [NumAxes];
  logic signed [32:0] tx_r, ty_r;
  logic [30:0]        ahw_r, ahh_r, bhw_r, bhh_r;

  always_comb begin
    logic signed [16:0] ac, as, bc, bs;
    logic signed [33:0] t0, t1, t2, t3;
    logic [33:0]        l2;
    ac = 17'(in_data.a_axis_cos);
    as = 17'(in_data.a_axis_sin);
    bc = 17'(in_data.b_axis_cos);
    bs = 17'(in_data.b_axis_sin);
    px_nxt[0] = ac;  py_nxt[0] = as;
    px_nxt[1] = -as; py_nxt[1] = ac;
    px_nxt[2] = bc;  py_nxt[2] = bs;
    px_nxt[3] = -bs; py_nxt[3] = bc;
    tx_nxt = 33'(in_data.b_center_x) - 33'(in_data.a_center_x);
    ty_nxt = 33'(in_data.b_center_y) - 33'(in_data.a_center_y);
    for (int i = 0; i < NumAxes; i++) begin
      t0 = 34'(ac) * 34'(px_nxt[i]) + 34'(as) * 34'(py_nxt[i]);
      t1 = 34'(bc) * 34'(py_nxt[i]) - 34'(bs) * 34'(px_nxt[i]);
      t2 = 34'(bc) * 34'(px_nxt[i]) + 34'(bs) * 34'(py_nxt[i]);
      t3 = 34'(ac) * 34'(py_nxt[i]) - 34'(as) * 34'(px_nxt[i]);
      dxa_nxt[i] = 32'(t0 < 0 ? -t0 : t0);
      dya_nxt[i] = 32'(t3 < 0 ? -t3 : t3);
      dxb_nxt[i] = 32'(t2 < 0 ? -t2 : t2);
      dyb_nxt[i] = 32'(t1 < 0 ? -t1 : t1);
      l2 = 34'(34'(px_nxt[i]) * 34'(px_nxt[i]) + 34'(py_nxt[i]) * 34'(py_nxt[i]));
      use_nxt[i] = (l2 >= 34'(AxisEpsQ28));
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1_r  <= px_nxt;  py1_r  <= py_nxt;
      dxa_r  <= dxa_nxt; dya_r  <= dya_nxt;
      dxb_r  <= dxb_nxt; dyb_r  <= dyb_nxt;
      use1_r <= use_nxt;
      tx_r   <= tx_nxt;  ty_r   <= ty_nxt;
      ahw_r  <= in_data.a_half_width;  ahh_r <= in_data.a_half_height;
      bhw_r  <= in_data.b_half_width;  bhh_r <= in_data.b_half_height;
    end
  end

  // ---------------- stage 2: radius and distance multiplies
  logic [62:0]        pax_r [NumAxes];
  logic [62:0]        pay_r [NumAxes];
  logic [62:0]        pbx_r [NumAxes];
  logic [62:0]        pby_r [NumAxes];
  logic signed [49:0] dpx_r [NumAxes];
  logic signed [49:0] dpy_r [NumAxes];
  logic signed [16:0] px2_r [NumAxes];
  logic signed [16:0] py2_r [NumAxes];
  logic               use2_r [NumAxes];

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < NumAxes; i++) begin
        pax_r[i] <= 63'(dxa_r[i]) * 63'(ahw_r);
        pay_r[i] <= 63'(dya_r[i]) * 63'(ahh_r);
        pbx_r[i] <= 63'(dxb_r[i]) * 63'(bhw_r);
        pby_r[i] <= 63'(dyb_r[i]) * 63'(bhh_r);
        dpx_r[i] <= 50'(tx_r) * 50'(px1_r[i]);
        dpy_r[i] <= 50'(ty_r) * 50'(py1_r[i]);
      end
      px2_r <= px1_r; py2_r <= py1_r; use2_r <= use1_r;
    end
  end

  // ---------------- stage 3: sums and rounding to Q16.16
  logic [34:0]        ra_r [NumAxes];
  logic [34:0]        rb_r [NumAxes];
  logic [35:0]        dist_r [NumAxes];
  logic               dneg3_r [NumAxes];
  logic signed [16:0] px3_r [NumAxes];
  logic signed [16:0] py3_r [NumAxes];
  logic               use3_r [NumAxes];

  always_ff @(posedge clk) begin
    logic [63:0]        sa, sb;
    logic signed [50:0] d;
    logic [50:0]        ad;
    if (en3) begin
      for (int i = 0; i < NumAxes; i++) begin
        sa = 64'(pax_r[i]) + 64'(pay_r[i]) + (64'd1 << 27);
        sb = 64'(pbx_r[i]) + 64'(pby_r[i]) + (64'd1 << 27);
        d  = 51'(dpx_r[i]) + 51'(dpy_r[i]);
        ad = d < 0 ? 51'(-d) : 51'(d);
        ra_r[i]    <= sa[62:28];
        rb_r[i]    <= sb[62:28];
        dist_r[i]  <= 36'((ad + (51'd1 << 13)) >> 14);
        dneg3_r[i] <= d < 0;
      end
      px3_r <= px2_r; py3_r <= py2_r; use3_r <= use2_r;
    end
  end

  // ---------------- stage 4: overlap per axis
  logic signed [37:0] ov_r [NumAxes];
  logic               dneg4_r [NumAxes];
  logic signed [16:0] px4_r [NumAxes];
  logic signed [16:0] py4_r [NumAxes];
  logic               use4_r [NumAxes];

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < NumAxes; i++) begin
        ov_r[i] <= signed'({3'b000, ra_r[i]}) + signed'({3'b000, rb_r[i]})
                 - signed'({2'b00, dist_r[i]});
      end
      dneg4_r <= dneg3_r; px4_r <= px3_r; py4_r <= py3_r; use4_r <= use3_r;
    end
  end

  // ---------------- stage 5: minimum selection, first axis wins ties
  obbsat_out_t out_nxt;

  always_comb begin
    logic               sep, have;
    logic signed [37:0] best;
    logic signed [17:0] nx, ny;
    sep = 1'b0; have = 1'b0; best = '0; nx = '0; ny = '0;
    for (int i = 0; i < NumAxes; i++) begin
      if (!sep && use4_r[i]) begin
        if (ov_r[i] <= 0) begin
          sep = 1'b1;
        end else if (!have || ov_r[i] < best) begin
          have = 1'b1;
          best = ov_r[i];
          nx = dneg4_r[i] ? -18'(px4_r[i]) : 18'(px4_r[i]);
          ny = dneg4_r[i] ? -18'(py4_r[i]) : 18'(py4_r[i]);
        end
      end
    end
    if (sep) begin
      out_nxt = '0;
    end else if (!have) begin
      out_nxt.overlapping   = 1'b1;
      out_nxt.push_normal_x = '0;
      out_nxt.push_normal_y = '0;
      out_nxt.push_depth    = DepthMax;
    end else begin
      out_nxt.overlapping   = 1'b1;
      out_nxt.push_normal_x = sat16(nx);
      out_nxt.push_normal_y = sat16(ny);
      out_nxt.push_depth    = (best > 38'(DepthMax)) ? DepthMax : best[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) out_data <= out_nxt;
  end

  // ---------------- checks
  a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.overlapping |->
      out_data.push_depth == '0 && out_data.push_normal_x == '0
      && out_data.push_normal_y == '0)
    else $error("separated result with non-zero push");

  a_depth_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overlapping |-> out_data.push_depth != '0)
    else $error("overlap with zero depth");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v5_r |-> in_ready)
    else $error("input stalled with empty output stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !out_ready && v4_r |=> v4_r && v5_r)
    else $error("pipeline data lost during stall");

endmodule
`default_nettype wire

>>> dv/obbsat_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module obbsat_checker
  import obbsat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire obbsat_in_t  in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire obbsat_out_t out_data,
  output int               fail_count,
  output int               pending
);

  obbsat_out_t expected_q[$];

  assign pending = expected_q.size();

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // radius of one rectangle projected onto an axis, rounded to Q16.16
  function automatic logic signed [63:0] radius_on_axis(
      input logic signed [63:0] c, input logic signed [63:0] s,
      input logic [63:0] hw, input logic [63:0] hh,
      input logic signed [63:0] px, input logic signed [63:0] py);
    logic [63:0] dx, dy, sum;
    dx = mag64(c * px + s * py);
    dy = mag64(-s * px + c * py);
    sum = dx * hw + dy * hh;
    return $signed((sum + (64'd1 << 27)) >> 28);
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [63:0] v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // minimum translation over the four candidate axes
  function automatic obbsat_out_t predict_push(input obbsat_in_t t);
    logic signed [63:0] ac, as, bc, bs, tx, ty, px, py, ra, rb, d, gap, ov;
    logic signed [63:0] best, nx, ny;
    logic signed [63:0] axx[4], axy[4];
    logic have, sep;
    obbsat_out_t r;
    ac = 64'(t.a_axis_cos); as = 64'(t.a_axis_sin);
    bc = 64'(t.b_axis_cos); bs = 64'(t.b_axis_sin);
    tx = 64'(t.b_center_x) - 64'(t.a_center_x);
    ty = 64'(t.b_center_y) - 64'(t.a_center_y);
    axx[0] = ac;  axy[0] = as;
    axx[1] = -as; axy[1] = ac;
    axx[2] = bc;  axy[2] = bs;
    axx[3] = -bs; axy[3] = bc;
    have = 1'b0; sep = 1'b0; best = '0; nx = '0; ny = '0;
    for (int i = 0; i < NumAxes; i++) begin
      px = axx[i]; py = axy[i];
      if (!sep && px * px + py * py >= 64'(AxisEpsQ28)) begin
        ra = radius_on_axis(ac, as, 64'(t.a_half_width), 64'(t.a_half_height), px, py);
        rb = radius_on_axis(bc, bs, 64'(t.b_half_width), 64'(t.b_half_height), px, py);
        d = tx * px + ty * py;
        gap = $signed((mag64(d) + (64'd1 << 13)) >> 14);
        ov = ra + rb - gap;
        if (ov <= 0) begin
          sep = 1'b1;
        end else if (!have || ov < best) begin
          have = 1'b1;
          best = ov;
          nx = d < 0 ? -px : px;
          ny = d < 0 ? -py : py;
        end
      end
    end
    r = '0;
    if (sep) begin
      r = '0;
    end else if (!have) begin
      r.overlapping = 1'b1;
      r.push_depth = DepthMax;
    end else begin
      r.overlapping = 1'b1;
      r.push_normal_x = clamp_q14(nx);
      r.push_normal_y = clamp_q14(ny);
      r.push_depth = best > 64'(DepthMax) ? DepthMax : best[30:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    obbsat_out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) expected_q = {expected_q, predict_push(in_data)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (out_data.overlapping !== e.overlapping)
            report_mismatch($sformatf("overlapping %0b exp %0b",
                                      out_data.overlapping, e.overlapping));
          if (out_data.push_normal_x !== e.push_normal_x)
            report_mismatch($sformatf("normal_x %0d exp %0d",
                                      out_data.push_normal_x, e.push_normal_x));
          if (out_data.push_normal_y !== e.push_normal_y)
            report_mismatch($sformatf("normal_y %0d exp %0d",
                                      out_data.push_normal_y, e.push_normal_y));
          if (out_data.push_depth !== e.push_depth)
            report_mismatch($sformatf("depth %0d exp %0d",
                                      out_data.push_depth, e.push_depth));
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_obb_obb_separating_axis.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_obb_obb_separating_axis;
  import obbsat_pkg::*;

  localparam int RandomPairs = 1800;
  localparam longint CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  obbsat_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  obbsat_out_t out_data;
  int          fail_count, pending;
  longint      cycle_count = 0;
  logic        quiet = 1'b0;
  int          sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  obb_obb_separating_axis u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  obbsat_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .fail_count, .pending
  );

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL obb_obb_separating_axis");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      n = $urandom_range(1, 18);
      out_ready <= quiet || ($urandom_range(0, 2) != 0);
      repeat (n) @(posedge clk);
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      3: return 16'sd0;
      4: return 16'($signed(16'($urandom_range(0, 200))) - 16'sd100);
      default: return 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384);
    endcase
  endfunction

  function automatic logic [30:0] rand_extent();
    case ($urandom_range(0, 7))
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF;
      2: return '0;
      default: return 31'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  // mostly nearby rectangles so overlap cases are common
  function automatic obbsat_in_t rand_pair();
    obbsat_in_t t;
    logic signed [31:0] base_x, base_y;
    base_x = $urandom;
    base_y = $urandom;
    t.a_axis_cos = rand_axis();   t.a_axis_sin = rand_axis();
    t.b_axis_cos = rand_axis();   t.b_axis_sin = rand_axis();
    t.a_half_width = rand_extent(); t.a_half_height = rand_extent();
    t.b_half_width = rand_extent(); t.b_half_height = rand_extent();
    if ($urandom_range(0, 4) == 0) begin
      t.a_center_x = $urandom; t.a_center_y = $urandom;
      t.b_center_x = $urandom; t.b_center_y = $urandom;
    end else begin
      t.a_center_x = base_x;
      t.a_center_y = base_y;
      t.b_center_x = base_x + 32'($signed(32'($urandom_range(0, 32'h0100_0000)))
                     - 32'sh0080_0000);
      t.b_center_y = base_y + 32'($signed(32'($urandom_range(0, 32'h0100_0000)))
                     - 32'sh0080_0000);
    end
    return t;
  endfunction

  // fields as plain integers, cut to the transaction's widths here
  function automatic obbsat_in_t build_pair(
      input int ax, ay, ac, as, ahw, ahh,
      input int bx, by, bc, bs, bhw, bhh);
    return '{ax, ay, 16'(ac), 16'(as), 31'(ahw), 31'(ahh),
             bx, by, 16'(bc), 16'(bs), 31'(bhw), 31'(bhh)};
  endfunction

  // one input transaction, sometimes with a random gap in front
  task automatic send_pair(input obbsat_in_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  localparam int One = 32'h0001_0000;

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: overlapping, separated, degenerate axes, extremes
    send_pair(build_pair(0, 0, 16384, 0, One, One, 32'sh0001_8000, 0, 16384, 0, One, One));
    send_pair(build_pair(0, 0, 16384, 0, One, One, 32'sh0003_0000, 0, 16384, 0, One, One));
    send_pair(build_pair(0, 0, 16384, 0, One, One, -32'sh0001_8000, 0, 16384, 0, One, One));
    send_pair(build_pair(0, 0, 16384, 0, One, One, 0, 32'sh0001_0000, 11585, 11585, One, One));
    send_pair(build_pair(0, 0, 0, 0, One, One, 5, 5, 0, 0, One, One));
    send_pair(build_pair(0, 0, 0, 0, One, One, 5, 5, 16384, 0, One, One));
    send_pair(build_pair(0, 0, 16384, 0, One, One, 0, 0, 16384, 0, One, One));
    send_pair(build_pair(0, 0, 16384, 0, '1, '1, 0, 0, 16384, 0, '1, '1));
    send_pair(build_pair(32'sh8000_0000, 32'sh8000_0000, -16384, -16384, '1, '1,
                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16384, 16384, '1, '1));
    send_pair(build_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 16384, 0, 0, 0,
                         32'sh8000_0000, 32'sh7FFF_FFFF, 0, 16384, 0, 0));
    send_pair(build_pair(0, 0, -32768, 0, One, One, 1, 0, -32768, -32768, One, One));
    send_pair(build_pair(0, 0, 32767, 32767, One, One, 0, 0, -32768, 32767, One, One));
    send_pair(build_pair(0, 0, 100, 0, One, One, 1, 1, 0, 164, One, One));
    send_pair(build_pair(0, 0, 16384, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
    send_pair(build_pair(0, 0, 16384, 0, One, One, 32'sh0002_0000, 0, 16384, 0, One, One));
    send_pair(build_pair(0, 0, 0, -16384, One, 2 * One, 0, -32'sh0001_0000, 0, 16384,
                         One, One));

    // let the pipeline drain completely once
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end

    for (int i = 0; i < RandomPairs; i++) begin
      if (i == RandomPairs - 200) quiet = 1'b1;
      send_pair(rand_pair());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS obb_obb_separating_axis");
    end else begin
      $display("FAIL obb_obb_separating_axis");
    end
    $finish;
  end

endmodule
`default_nettype wire
